// ===== src/ledscan_pkg.sv =====
`default_nettype none

package ledscan_pkg;

   // field widths fixed by the bus format
   localparam int WORD_BITS      = 32;
   localparam int ROW_SEL_BITS   = 4;
   localparam int COLOUR_BITS    = 2;
   localparam int ON_TIME_BITS   = 8;
   localparam int STEP_BITS      = 8;
   localparam int PIN_COUNT      = 9;
   localparam int REQ_DATA_BITS  = 40;
   localparam int RSP_DATA_BITS  = 16;

   localparam int DEFAULT_ROWS    = 14;
   localparam int DEFAULT_COLUMNS = 32;
   localparam int DEFAULT_COLOURS = 3;

   localparam logic [ON_TIME_BITS-1:0] ON_TIME_RESET = 8'd80;

   // beat kinds on req_tuser
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // pin positions in the pin level word
   localparam int PIN_RCLK  = 0;
   localparam int PIN_RDATA = 1;
   localparam int PIN_RLAT  = 2;
   localparam int PIN_CCLK  = 3;
   localparam int PIN_RED   = 4;
   localparam int PIN_GREEN = 5;
   localparam int PIN_BLUE  = 6;
   localparam int PIN_CLAT  = 7;
   localparam int PIN_OEN   = 8;

   localparam logic [PIN_COUNT-1:0] PINS_RESET = 9'h100;

   typedef enum logic [1:0] {
      PH_ROW_SHIFT,
      PH_COL_SHIFT,
      PH_LATCH,
      PH_ON
   } scan_phase_type;

endpackage

`default_nettype wire

// ===== src/ledscan_frame_store.sv =====
`default_nettype none

// One colour plane: one word per row, write-through onto the read register
// so rd_word shows the current content of the row that rd_row selected at the last edge.
module ledscan_frame_store #(
   parameter int ROWS = ledscan_pkg::DEFAULT_ROWS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_en,
   input  wire logic [$clog2(ROWS)-1:0]             wr_row,
   input  wire logic [ledscan_pkg::WORD_BITS-1:0]   wr_word,
   input  wire logic [$clog2(ROWS)-1:0]             rd_row,
   output      logic [ledscan_pkg::WORD_BITS-1:0]   rd_word
);

   logic [ledscan_pkg::WORD_BITS-1:0] mem_ff [ROWS];
   logic [ROWS-1:0]                   valid_ff;
   logic [ledscan_pkg::WORD_BITS-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_row] <= 1'b1;
      end
   end

   // unwritten rows read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
      end else if (wr_en && (wr_row == rd_row)) begin
         rd_ff <= wr_word;
      end else if (valid_ff[rd_row]) begin
         rd_ff <= mem_ff[rd_row];
      end else begin
         rd_ff <= '0;
      end
   end

   assign rd_word = rd_ff;

endmodule

`default_nettype wire

// ===== src/rgb_led_matrix_row_scanner.sv =====
// The pin levels of a tick beat are registered at the edge that accepts the beat and then shown on rsp.
// Throughput: one beat per cycle while rsp is not stalled; write beats give no result, tick beats give one.
// Each colour plane is one row-wide store; its read register tracks the scanned row.
// Reset (synchronous): store reads all zero, row 0, row shift phase, on time 80,
// pins low except output enable high.
`default_nettype none

module rgb_led_matrix_row_scanner #(
   parameter int ROWS    = ledscan_pkg::DEFAULT_ROWS,
   parameter int COLUMNS = ledscan_pkg::DEFAULT_COLUMNS,
   parameter int COLOURS = ledscan_pkg::DEFAULT_COLOURS
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     csr_wr_en,
   input  wire logic [ledscan_pkg::ON_TIME_BITS-1:0]     csr_wr_data,
   input  wire logic                                     req_tvalid,
   output      logic                                     req_tready,
   // row_select[3:0], colour_select[5:4], column_bits[37:6], zero fill
   input  wire logic [ledscan_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // cmd
   input  wire logic                                     req_tuser,
   output      logic                                     rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // row_shift_clock[0], row_shift_data[1], row_latch[2], column_clock[3],
   // red_data[4], green_data[5], blue_data[6], column_latch[7],
   // output_enable_n[8], scan_row[12:9], zero fill
   output      logic [ledscan_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);

   localparam int RW         = $clog2(ROWS);
   localparam int ROW_TICKS  = 2 * ROWS;
   localparam int COL_TICKS  = 2 * COLUMNS;

   logic [ledscan_pkg::ROW_SEL_BITS-1:0] req_row;
   logic [ledscan_pkg::COLOUR_BITS-1:0]  req_colour;
   logic [ledscan_pkg::WORD_BITS-1:0]    req_word;
   logic                                 req_fire;
   logic                                 tick;
   logic                                 wr_ok;

   logic [ledscan_pkg::ON_TIME_BITS-1:0] on_time_ff;
   ledscan_pkg::scan_phase_type          phase_ff, phase_in;
   logic [ledscan_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic [RW-1:0]                        row_ff, row_in;
   logic [ledscan_pkg::PIN_COUNT-1:0]    pins_ff, pins_in;
   logic                                 rsp_valid_ff;
   logic [3:0]                           rsp_row_ff;

   logic [ledscan_pkg::STEP_BITS:0]      step_inc;
   logic [ledscan_pkg::ON_TIME_BITS-1:0] on_lim;
   logic [ledscan_pkg::STEP_BITS-2:0]    pos;
   logic                                 half;
   logic [2:0]                           plane_bit;

   assign req_row    = req_tdata[3:0];
   assign req_colour = req_tdata[5:4];
   assign req_word   = req_tdata[37:6];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign tick       = req_fire && (req_tuser == ledscan_pkg::CMD_TICK);
   assign wr_ok      = req_fire && (req_tuser == ledscan_pkg::CMD_WRITE)
                       && (32'(req_row) < ROWS);

   assign step_inc = {1'b0, step_ff} + 1'b1;
   assign on_lim   = (on_time_ff == '0) ? 8'd1 : on_time_ff;
   assign pos      = step_ff[ledscan_pkg::STEP_BITS-1:1];
   assign half     = step_ff[0];

   // colour planes
   for (genvar c = 0; c < 3; c++) begin : g_plane
      if (c < COLOURS) begin : g_used
         logic [ledscan_pkg::WORD_BITS-1:0] word;

         ledscan_frame_store #(
            .ROWS (ROWS)
         ) u_store (
            .clock   (clock),
            .reset   (reset),
            .wr_en   (wr_ok && (req_colour == 2'(c))),
            .wr_row  (RW'(req_row)),
            .wr_word (req_word),
            .rd_row  (row_in),
            .rd_word (word)
         );

         // columns past the stored word shift zero
         assign plane_bit[c] = (pos[6:5] == 2'b00) ? word[pos[4:0]] : 1'b0;
      end else begin : g_absent
         assign plane_bit[c] = 1'b0;
      end
   end

   // sequencer next state
   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      row_in   = row_ff;
      if (tick) begin
         unique case (phase_ff)
            ledscan_pkg::PH_ROW_SHIFT: begin
               if (step_inc >= 9'(ROW_TICKS)) begin
                  step_in  = '0;
                  phase_in = ledscan_pkg::PH_COL_SHIFT;
               end else begin
                  step_in = step_inc[ledscan_pkg::STEP_BITS-1:0];
               end
            end
            ledscan_pkg::PH_COL_SHIFT: begin
               if (step_inc >= 9'(COL_TICKS)) begin
                  step_in  = '0;
                  phase_in = ledscan_pkg::PH_LATCH;
               end else begin
                  step_in = step_inc[ledscan_pkg::STEP_BITS-1:0];
               end
            end
            ledscan_pkg::PH_LATCH: begin
               step_in  = '0;
               phase_in = ledscan_pkg::PH_ON;
            end
            ledscan_pkg::PH_ON: begin
               if (step_inc >= {1'b0, on_lim}) begin
                  step_in  = '0;
                  phase_in = ledscan_pkg::PH_ROW_SHIFT;
                  row_in   = (32'(row_ff) >= ROWS - 1) ? '0 : row_ff + 1'b1;
               end else begin
                  step_in = step_inc[ledscan_pkg::STEP_BITS-1:0];
               end
            end
            default: begin
               phase_in = ledscan_pkg::PH_ROW_SHIFT;
            end
         endcase
      end
   end

   // pin levels; pins a phase does not drive keep their level
   always_comb begin
      pins_in = pins_ff;
      if (tick) begin
         unique case (phase_ff)
            ledscan_pkg::PH_ROW_SHIFT: begin
               pins_in[ledscan_pkg::PIN_OEN]   = 1'b1;
               pins_in[ledscan_pkg::PIN_RLAT]  = 1'b0;
               pins_in[ledscan_pkg::PIN_RCLK]  = half;
               pins_in[ledscan_pkg::PIN_RDATA] = (pos == 7'(row_ff));
            end
            ledscan_pkg::PH_COL_SHIFT: begin
               pins_in[ledscan_pkg::PIN_RLAT]  = 1'b1;
               pins_in[ledscan_pkg::PIN_CCLK]  = half;
               pins_in[ledscan_pkg::PIN_RED]   = plane_bit[0];
               pins_in[ledscan_pkg::PIN_GREEN] = plane_bit[1];
               pins_in[ledscan_pkg::PIN_BLUE]  = plane_bit[2];
            end
            ledscan_pkg::PH_LATCH: begin
               pins_in[ledscan_pkg::PIN_CLAT]  = 1'b1;
            end
            ledscan_pkg::PH_ON: begin
               pins_in[ledscan_pkg::PIN_CLAT]  = 1'b0;
               pins_in[ledscan_pkg::PIN_OEN]   = 1'b0;
            end
            default: begin
               pins_in = pins_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_time_ff <= ledscan_pkg::ON_TIME_RESET;
      end else if (csr_wr_en) begin
         on_time_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ledscan_pkg::PH_ROW_SHIFT;
         step_ff      <= '0;
         row_ff       <= '0;
         pins_ff      <= ledscan_pkg::PINS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         row_ff   <= row_in;
         pins_ff  <= pins_in;
         if (tick) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // row shown with a beat is the row before any wrap
   always_ff @(posedge clock) begin
      if (tick) begin
         rsp_row_ff <= 4'(row_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_row_ff, pins_ff};

   // outputs are only enabled after the row latch has gone high
   a_oen_after_rlat : assert property (@(posedge clock) disable iff (reset)
      !pins_ff[ledscan_pkg::PIN_OEN] |-> pins_ff[ledscan_pkg::PIN_RLAT])
      else $error("outputs enabled while row latch low");

   // column latch pulse only while outputs are blanked
   a_clat_blanked : assert property (@(posedge clock) disable iff (reset)
      pins_ff[ledscan_pkg::PIN_CLAT] |-> pins_ff[ledscan_pkg::PIN_OEN])
      else $error("column latch while outputs enabled");

   a_row_range : assert property (@(posedge clock) disable iff (reset)
      32'(row_ff) < ROWS)
      else $error("scan row out of range");

   a_row_steps : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ledscan_pkg::PH_ROW_SHIFT) |-> (32'(step_ff) < ROW_TICKS))
      else $error("row shift step count overrun");

endmodule

`default_nettype wire

// ===== dv/scan_pin_sb_pkg.sv =====
package scan_pin_sb_pkg;

   import ledscan_pkg::*;

   class scan_pin_scoreboard;
      logic [WORD_BITS-1:0]     plane_word [DEFAULT_ROWS*DEFAULT_COLOURS];
      int unsigned              scan_row;
      scan_phase_type           phase;
      int unsigned              step;
      logic [PIN_COUNT-1:0]     pins;
      logic [ON_TIME_BITS-1:0]  on_time;
      logic [RSP_DATA_BITS-1:0] pin_words_due[$];
      string                    pin_names [PIN_COUNT];
      int unsigned              mismatches;
      int unsigned              words_seen;

      function new();
         foreach (plane_word[i]) plane_word[i] = '0;
         scan_row    = 0;
         phase       = PH_ROW_SHIFT;
         step        = 0;
         pins        = PINS_RESET;
         on_time     = ON_TIME_RESET;
         mismatches  = 0;
         words_seen  = 0;
         pin_names[PIN_RCLK]  = "row_shift_clock";
         pin_names[PIN_RDATA] = "row_shift_data";
         pin_names[PIN_RLAT]  = "row_latch";
         pin_names[PIN_CCLK]  = "column_clock";
         pin_names[PIN_RED]   = "red_data";
         pin_names[PIN_GREEN] = "green_data";
         pin_names[PIN_BLUE]  = "blue_data";
         pin_names[PIN_CLAT]  = "column_latch";
         pin_names[PIN_OEN]   = "output_enable_n";
      endfunction

      function logic plane_bit(int unsigned colour, int unsigned column);
         if (colour >= DEFAULT_COLOURS || column >= WORD_BITS) return 1'b0;
         return plane_word[scan_row*DEFAULT_COLOURS + colour][column];
      endfunction

      // Accepted req beat: writes update the store, ticks step the scan and queue a pin word.
      function void note_beat(logic cmd, logic [REQ_DATA_BITS-1:0] data);
         logic [ROW_SEL_BITS-1:0]  row_sel;
         logic [COLOUR_BITS-1:0]   colour_sel;
         logic [RSP_DATA_BITS-1:0] word;
         logic                     half;
         int unsigned              pos;
         int unsigned              limit;
         row_sel    = data[ROW_SEL_BITS-1:0];
         colour_sel = data[ROW_SEL_BITS +: COLOUR_BITS];
         if (cmd == CMD_WRITE) begin
            // out-of-range row or colour is dropped
            if (row_sel < DEFAULT_ROWS && colour_sel < DEFAULT_COLOURS)
               plane_word[row_sel*DEFAULT_COLOURS + colour_sel] =
                  data[ROW_SEL_BITS+COLOUR_BITS +: WORD_BITS];
            return;
         end

         half = step[0];
         pos  = step >> 1;
         case (phase)
            PH_ROW_SHIFT: begin
               pins[PIN_OEN]   = 1'b1;
               pins[PIN_RLAT]  = 1'b0;
               pins[PIN_RCLK]  = half;
               pins[PIN_RDATA] = (pos == scan_row);
            end
            PH_COL_SHIFT: begin
               pins[PIN_RLAT]  = 1'b1;
               pins[PIN_CCLK]  = half;
               pins[PIN_RED]   = plane_bit(0, pos);
               pins[PIN_GREEN] = plane_bit(1, pos);
               pins[PIN_BLUE]  = plane_bit(2, pos);
            end
            PH_LATCH: pins[PIN_CLAT] = 1'b1;
            default: begin
               pins[PIN_CLAT] = 1'b0;
               pins[PIN_OEN]  = 1'b0;
            end
         endcase
         word = '0;
         word[PIN_COUNT-1:0] = pins;
         word[PIN_COUNT +: ROW_SEL_BITS] = scan_row[ROW_SEL_BITS-1:0];
         pin_words_due.push_back(word);

         step++;
         case (phase)
            PH_ROW_SHIFT: if (step >= 2*DEFAULT_ROWS) begin
               step  = 0;
               phase = PH_COL_SHIFT;
            end
            PH_COL_SHIFT: if (step >= 2*DEFAULT_COLUMNS) begin
               step  = 0;
               phase = PH_LATCH;
            end
            PH_LATCH: begin
               step  = 0;
               phase = PH_ON;
            end
            default: begin
               // zero on time behaves as one; a lowered value ends the phase at once
               limit = (on_time == 0) ? 1 : on_time;
               if (step >= limit) begin
                  step     = 0;
                  phase    = PH_ROW_SHIFT;
                  scan_row = (scan_row + 1 >= DEFAULT_ROWS) ? 0 : scan_row + 1;
               end
            end
         endcase
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 100) $display("MISMATCH pin word %0d: %s", words_seen, what);
      endtask

      task check_pins(logic [RSP_DATA_BITS-1:0] got);
         logic [RSP_DATA_BITS-1:0] want;
         words_seen++;
         if (pin_words_due.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h", got));
            return;
         end
         want = pin_words_due.pop_front();
         for (int j = 0; j < PIN_COUNT; j++) begin
            if (got[j] !== want[j])
               report_mismatch($sformatf("%s got %b want %b", pin_names[j], got[j], want[j]));
         end
         if (got[PIN_COUNT +: ROW_SEL_BITS] !== want[PIN_COUNT +: ROW_SEL_BITS])
            report_mismatch($sformatf("scan_row got %0d want %0d",
                                      got[PIN_COUNT +: ROW_SEL_BITS],
                                      want[PIN_COUNT +: ROW_SEL_BITS]));
         if (got[RSP_DATA_BITS-1:PIN_COUNT+ROW_SEL_BITS] !== '0)
            report_mismatch($sformatf("fill bits not zero: %h", got));
      endtask
   endclass

endpackage

// ===== dv/rgb_led_matrix_row_scanner_tb.sv =====
module rgb_led_matrix_row_scanner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ledscan_pkg::*;
   import scan_pin_sb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      csr_wr_en   = 1'b0;
   logic [ON_TIME_BITS-1:0]   csr_wr_data = '0;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata   = '0;
   logic                      req_tuser   = CMD_TICK;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;

   scan_pin_scoreboard pin_sb;
   int                 send_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   int unsigned        cycle_count   = 0;

   rgb_led_matrix_row_scanner DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) pin_sb.check_pins(rsp_tdata);
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [REQ_DATA_BITS-1:0] pack_req(logic [ROW_SEL_BITS-1:0] row_sel,
                                                         logic [COLOUR_BITS-1:0]  colour_sel,
                                                         logic [WORD_BITS-1:0]    bits);
      logic [REQ_DATA_BITS-1:0] data;
      data = '0;
      data[ROW_SEL_BITS-1:0] = row_sel;
      data[ROW_SEL_BITS +: COLOUR_BITS] = colour_sel;
      data[ROW_SEL_BITS+COLOUR_BITS +: WORD_BITS] = bits;
      return data;
   endfunction

   task automatic send_beat(input logic cmd, input logic [REQ_DATA_BITS-1:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pin_sb.note_beat(cmd, data);
   endtask

   task automatic send_tick();
      send_beat(CMD_TICK, pack_req(ROW_SEL_BITS'($urandom_range(0, 15)),
                                   COLOUR_BITS'($urandom_range(0, 3)),
                                   WORD_BITS'($urandom())));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pin_sb.pin_words_due.size() != 0) @(posedge clock);
      // a trailing write beat may still be in the pipe
      repeat (3) @(posedge clock);
   endtask

   task automatic write_on_time(input logic [ON_TIME_BITS-1:0] value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pin_sb.on_time = value;
   endtask

   initial begin : stimulus
      logic [WORD_BITS-1:0]    bits;
      logic [ROW_SEL_BITS-1:0] row_sel;
      logic [COLOUR_BITS-1:0]  colour_sel;
      int                      pick;

      pin_sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corner words, out-of-range writes, a few ticks at reset on time
      send_beat(CMD_WRITE, pack_req(4'd0, 2'd0, 32'hFFFF_FFFF));
      send_beat(CMD_WRITE, pack_req(4'd0, 2'd1, 32'h0000_0001));
      send_beat(CMD_WRITE, pack_req(4'd0, 2'd2, 32'h8000_0000));
      send_beat(CMD_WRITE, pack_req(4'd13, 2'd2, 32'hFFFF_FFFF));
      send_beat(CMD_WRITE, pack_req(4'd13, 2'd0, 32'h0000_0000));
      send_beat(CMD_WRITE, pack_req(4'd1, 2'd0, 32'h5555_AAAA));
      send_beat(CMD_WRITE, pack_req(4'd14, 2'd0, 32'hAAAA_AAAA));
      send_beat(CMD_WRITE, pack_req(4'd15, 2'd2, 32'h5555_5555));
      send_beat(CMD_WRITE, pack_req(4'd0, 2'd3, 32'h1234_5678));
      send_beat(CMD_WRITE, pack_req(4'd13, 2'd3, 32'hDEAD_BEEF));
      repeat (6) send_beat(CMD_TICK, pack_req(4'd15, 2'd3, 32'hFFFF_FFFF));
      send_beat(CMD_TICK, pack_req(4'd0, 2'd0, 32'h0000_0000));

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 64; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 64; end
            default: begin send_idle_pct = 35; rsp_stall_pct <= 35; end
         endcase
         for (int blk = 0; blk < 4; blk++) begin
            if (blk == 0) begin
               case (ph)
                  0: write_on_time(8'd0);
                  1: write_on_time(8'd1);
                  2: begin
                     // drop the on time while the row is well into its on phase
                     write_on_time(8'd255);
                     while (!(pin_sb.phase == PH_ON && pin_sb.step >= 20)) send_tick();
                     write_on_time(8'd2);
                  end
                  default: write_on_time(8'd255);
               endcase
            end else begin
               pick = $urandom_range(0, 9);
               if (pick == 0)      write_on_time(8'd0);
               else if (pick == 1) write_on_time(8'd255);
               else if (pick == 2) write_on_time(ON_TIME_BITS'($urandom_range(7, 40)));
               else                write_on_time(ON_TIME_BITS'($urandom_range(1, 6)));
            end

            repeat (25) begin
               if ($urandom_range(0, 99) < 84) begin
                  send_tick();
               end else begin
                  row_sel    = ($urandom_range(0, 9) == 0)
                               ? ROW_SEL_BITS'($urandom_range(14, 15))
                               : ROW_SEL_BITS'($urandom_range(0, 13));
                  colour_sel = ($urandom_range(0, 9) == 0) ? 2'd3
                                                           : COLOUR_BITS'($urandom_range(0, 2));
                  case ($urandom_range(0, 5))
                     0: bits = '0;
                     1: bits = '1;
                     2: bits = 32'h1 << $urandom_range(0, 31);
                     default: bits = $urandom();
                  endcase
                  send_beat(CMD_WRITE, pack_req(row_sel, colour_sel, bits));
               end
            end
         end
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (pin_sb.mismatches == 0 && pin_sb.pin_words_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/ledscan_pkg.sv
src/ledscan_frame_store.sv
src/rgb_led_matrix_row_scanner.sv
dv/scan_pin_sb_pkg.sv
dv/rgb_led_matrix_row_scanner_tb.sv
